// ----- design/assert_macros.svh -----
// Assertion helpers shared by the RTL. Both expect clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PFF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be true outside reset.
`define PFF_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- design/pff_pkg.sv -----
package pff_pkg;

  localparam int NUM_OBJ   = 3;
  localparam int TAG_W     = 16;
  localparam int CNT_OUT_W = 5;
  localparam int COUNT_MAX = 31;

  // Per-lane compare outcome for one stored entry against the candidate.
  typedef struct packed {
    logic ent_dom;   // stored entry dominates the candidate
    logic cand_dom;  // candidate dominates the stored entry
  } lane_res_t;

  // Sequencing strobes from the controller to the merge stage.
  typedef struct packed {
    logic clear;     // new candidate: reset the accumulators
    logic acc;       // lane results of one pass are valid
    logic commit;    // apply the decision to the front
  } merge_ctrl_t;

  // Decision for the current candidate.
  typedef struct packed {
    logic kept;
    logic dominated;
    logic overflow;
  } res_flags_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SWEEP  = 4'b0010,
    S_LAST   = 4'b0100,
    S_COMMIT = 4'b1000
  } pff_state_e;

endpackage

// ----- design/pff_if.sv -----
interface pff_in_if #(
  parameter int OBJ_WIDTH = 32
);
  logic                 valid;
  logic                 ready;
  logic [15:0]          solution_tag;
  logic [OBJ_WIDTH-1:0] obj_0;
  logic [OBJ_WIDTH-1:0] obj_1;
  logic [OBJ_WIDTH-1:0] obj_2;

  modport source (output valid, solution_tag, obj_0, obj_1, obj_2, input ready);
  modport sink   (input valid, solution_tag, obj_0, obj_1, obj_2, output ready);
endinterface

interface pff_out_if;
  logic       valid;
  logic       ready;
  logic       kept;
  logic       dominated_by_front;
  logic       overflow_drop;
  logic [4:0] removed_count;
  logic [4:0] front_size;

  modport source (output valid, kept, dominated_by_front, overflow_drop, removed_count,
                  front_size, input ready);
  modport sink   (input valid, kept, dominated_by_front, overflow_drop, removed_count,
                  front_size, output ready);
endinterface

// ----- design/pff_lane.sv -----
module pff_lane #(
  parameter int OBJ_WIDTH = 32,
  parameter int PASSES    = 4,
  localparam int PassW    = (PASSES > 1) ? $clog2(PASSES) : 1
) (
  input  logic                                          clk_i,
  input  logic [pff_pkg::NUM_OBJ-1:0][OBJ_WIDTH-1:0]    cand_i,
  input  logic [pff_pkg::TAG_W-1:0]                     tag_i,
  input  logic [PassW-1:0]                              rd_addr_i,
  input  logic                                          wr_en_i,
  input  logic [PassW-1:0]                              wr_addr_i,
  output pff_pkg::lane_res_t                            res_o
);
  import pff_pkg::*;

  localparam int ObjBits = NUM_OBJ * OBJ_WIDTH;
  localparam int EntryW  = ObjBits + TAG_W;

  logic [EntryW-1:0]                   mem_q [PASSES];
  logic [EntryW-1:0]                   rd_q;
  logic [NUM_OBJ-1:0][OBJ_WIDTH-1:0]   ent_obj;
  logic [NUM_OBJ-1:0]                  ent_lt;
  logic [NUM_OBJ-1:0]                  cand_lt;

  // Bank of this lane: one entry per pass, registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= {tag_i, cand_i};
    end
    rd_q <= mem_q[rd_addr_i];
  end

  assign ent_obj = rd_q[ObjBits-1:0];

  // Keys are order keys, so unsigned compares give signed order.
  always_comb begin
    for (int k = 0; k < NUM_OBJ; k++) begin
      ent_lt[k]  = ent_obj[k] < cand_i[k];
      cand_lt[k] = cand_i[k] < ent_obj[k];
    end
  end

  assign res_o.ent_dom  = (cand_lt == '0) && (ent_lt != '0);
  assign res_o.cand_dom = (ent_lt == '0) && (cand_lt != '0);

endmodule

// ----- design/pff_merge.sv -----
`include "assert_macros.svh"

module pff_merge #(
  parameter int FRONT_DEPTH = 16,
  parameter int NUM_LANES   = 4,
  localparam int PASSES     = (FRONT_DEPTH + NUM_LANES - 1) / NUM_LANES,
  localparam int PassW      = (PASSES > 1) ? $clog2(PASSES) : 1,
  localparam int LaneW      = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1,
  localparam int CntW       = $clog2(FRONT_DEPTH + 1)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  pff_pkg::merge_ctrl_t                  ctrl_i,
  input  logic [PassW-1:0]                      pass_i,
  input  pff_pkg::lane_res_t [NUM_LANES-1:0]    res_i,
  output pff_pkg::res_flags_t                   flags_o,
  output logic [CntW-1:0]                       removed_o,
  output logic [CntW-1:0]                       size_next_o,
  output logic [NUM_LANES-1:0]                  wr_lane_o,
  output logic [PassW-1:0]                      wr_pass_o
);
  import pff_pkg::*;

  logic [PASSES-1:0][NUM_LANES-1:0] exist;
  logic [PASSES-1:0][NUM_LANES-1:0] valid_q, valid_d;
  logic [PASSES-1:0][NUM_LANES-1:0] rm_mask_q;
  logic                             dom_q, found_q;
  logic [CntW-1:0]                  rm_cnt_q, size_q;
  logic [PassW-1:0]                 slot_pass_q;
  logic [LaneW-1:0]                 slot_lane_q;

  logic [NUM_LANES-1:0]             row_valid, row_exist, beat, free;
  logic                             dom_any;
  logic [CntW-1:0]                  pass_cnt;
  logic [LaneW-1:0]                 free_lane;
  logic                             kept;

  // Slots past the front depth in the last pass do not exist.
  for (genvar gp = 0; gp < PASSES; gp++) begin : g_pass
    for (genvar gl = 0; gl < NUM_LANES; gl++) begin : g_lane
      assign exist[gp][gl] = (gp * NUM_LANES + gl) < FRONT_DEPTH;
    end
  end

  // Combine the lanes of one pass.
  always_comb begin
    row_valid = valid_q[pass_i];
    row_exist = exist[pass_i];
    dom_any   = 1'b0;
    pass_cnt  = '0;
    free_lane = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      dom_any  = dom_any | (row_valid[l] & res_i[l].ent_dom);
      beat[l]  = row_valid[l] & res_i[l].cand_dom;
      free[l]  = row_exist[l] & (~row_valid[l] | res_i[l].cand_dom);
      pass_cnt = pass_cnt + CntW'(beat[l]);
    end
    for (int l = NUM_LANES - 1; l >= 0; l--) begin
      if (free[l]) begin
        free_lane = LaneW'(l);
      end
    end
  end

  assign kept              = ~dom_q & found_q;
  assign flags_o.kept      = kept;
  assign flags_o.dominated = dom_q;
  assign flags_o.overflow  = ~dom_q & ~found_q;
  assign removed_o         = dom_q ? '0 : rm_cnt_q;
  assign size_next_o       = size_q - removed_o + CntW'(kept);
  assign wr_pass_o         = slot_pass_q;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      wr_lane_o[l] = ctrl_i.commit & kept & (slot_lane_q == LaneW'(l));
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (!dom_q) begin
      valid_d = valid_q & ~rm_mask_q;
      if (found_q) begin
        valid_d[slot_pass_q][slot_lane_q] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      rm_mask_q   <= '0;
      dom_q       <= 1'b0;
      found_q     <= 1'b0;
      rm_cnt_q    <= '0;
      size_q      <= '0;
      slot_pass_q <= '0;
      slot_lane_q <= '0;
    end else if (ctrl_i.clear) begin
      rm_mask_q <= '0;
      dom_q     <= 1'b0;
      found_q   <= 1'b0;
      rm_cnt_q  <= '0;
    end else if (ctrl_i.acc) begin
      dom_q             <= dom_q | dom_any;
      rm_mask_q[pass_i] <= beat;
      rm_cnt_q          <= rm_cnt_q + pass_cnt;
      if (!found_q && (free != '0)) begin
        found_q     <= 1'b1;
        slot_pass_q <= pass_i;
        slot_lane_q <= free_lane;
      end
    end else if (ctrl_i.commit) begin
      valid_q   <= valid_d;
      size_q    <= size_next_o;
      rm_mask_q <= '0;
    end
  end

  `PFF_ASSERT(a_size_matches_valid, $countones(valid_q) == int'(size_q), "front size out of sync")
  `PFF_ASSERT_NEVER(a_rm_outside_valid, (rm_mask_q & ~valid_q) != '0, "removal of empty slot")
  `PFF_ASSERT_NEVER(a_pad_slot_valid, (valid_q & ~exist) != '0, "nonexistent slot marked valid")

endmodule

// ----- design/pareto_front_filter_top.sv -----
// Bounded Pareto front filter, all objectives minimized. Each transfer on cand_i is one
// candidate (tag plus three signed Q16.16 objectives); each candidate yields exactly one
// transfer on res_o reporting whether it was kept, dominated by the front, or dropped
// because all FRONT_DEPTH slots stayed occupied, with the number of entries it evicted
// and the front size afterwards (both saturate at 31). NUM_LANES compare lanes each own
// one bank of the store and test one entry per cycle. A candidate runs through the
// sweep, one bank row per pass, the last state for the registered read of the final
// row, and the commit state, which waits while the output register is full and not
// taken, then returns to idle. One candidate is in flight at a time; a finished
// result waits in the output register while the next candidate is already taken in.
// Candidates with equal objectives are both kept. Stored entries are undefined until
// written but are only read behind their valid bits, which reset clears at once.
`include "assert_macros.svh"

module pareto_front_filter_top #(
  parameter int FRONT_DEPTH = 16,
  parameter int OBJ_WIDTH   = 32,
  parameter int NUM_LANES   = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pff_in_if.sink       cand_i,
  pff_out_if.source    res_o
);
  import pff_pkg::*;

  localparam int PASSES = (FRONT_DEPTH + NUM_LANES - 1) / NUM_LANES;
  localparam int PassW  = (PASSES > 1) ? $clog2(PASSES) : 1;
  localparam int CntW   = $clog2(FRONT_DEPTH + 1);

  pff_state_e                         state_q, state_d;
  logic [PassW-1:0]                   pass_q;
  logic                               cmp_vld_q;
  logic [PassW-1:0]                   cmp_pass_q;
  logic [NUM_OBJ-1:0][OBJ_WIDTH-1:0]  cand_q;
  logic [TAG_W-1:0]                   tag_q;

  logic                               in_xfer, commit;
  merge_ctrl_t                        ctrl;
  lane_res_t [NUM_LANES-1:0]          lane_res;
  res_flags_t                         flags;
  logic [CntW-1:0]                    removed, size_next;
  logic [NUM_LANES-1:0]               wr_lane;
  logic [PassW-1:0]                   wr_pass;

  logic                               out_valid_q;
  res_flags_t                         out_flags_q;
  logic [CNT_OUT_W-1:0]               out_removed_q, out_size_q;

  // Accept only between candidates; the result register decouples the output side.
  assign cand_i.ready = (state_q == S_IDLE);
  assign in_xfer      = cand_i.valid & cand_i.ready;
  assign commit       = (state_q == S_COMMIT) & (~out_valid_q | res_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_xfer) state_d = S_SWEEP;
      S_SWEEP:  if (pass_q == PassW'(PASSES - 1)) state_d = S_LAST;
      S_LAST:   state_d = S_COMMIT;
      S_COMMIT: if (commit) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pass_q     <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_pass_q <= '0;
    end else begin
      state_q    <= state_d;
      // Results of the row read this cycle reach the merge stage next cycle.
      cmp_vld_q  <= (state_q == S_SWEEP);
      cmp_pass_q <= pass_q;
      if (in_xfer) begin
        pass_q <= '0;
      end else if (state_q == S_SWEEP) begin
        pass_q <= pass_q + PassW'(1);
      end
    end
  end

  // Hold the candidate as order keys: flip the sign bit so unsigned compare is signed.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      tag_q     <= cand_i.solution_tag;
      cand_q[0] <= {~cand_i.obj_0[OBJ_WIDTH-1], cand_i.obj_0[OBJ_WIDTH-2:0]};
      cand_q[1] <= {~cand_i.obj_1[OBJ_WIDTH-1], cand_i.obj_1[OBJ_WIDTH-2:0]};
      cand_q[2] <= {~cand_i.obj_2[OBJ_WIDTH-1], cand_i.obj_2[OBJ_WIDTH-2:0]};
    end
  end

  // One lane per bank; lane l owns entries pass * NUM_LANES + l.
  for (genvar gl = 0; gl < NUM_LANES; gl++) begin : g_lane
    pff_lane #(
      .OBJ_WIDTH (OBJ_WIDTH),
      .PASSES    (PASSES)
    ) u_lane (
      .clk_i     (clk_i),
      .cand_i    (cand_q),
      .tag_i     (tag_q),
      .rd_addr_i (pass_q),
      .wr_en_i   (wr_lane[gl]),
      .wr_addr_i (wr_pass),
      .res_o     (lane_res[gl])
    );
  end

  assign ctrl.clear  = in_xfer;
  assign ctrl.acc    = cmp_vld_q;
  assign ctrl.commit = commit;

  // Merge stage: accumulates dominance, evictions and the first free slot over passes,
  // then applies the decision to the valid bits on commit.
  pff_merge #(
    .FRONT_DEPTH (FRONT_DEPTH),
    .NUM_LANES   (NUM_LANES)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .pass_i      (cmp_pass_q),
    .res_i       (lane_res),
    .flags_o     (flags),
    .removed_o   (removed),
    .size_next_o (size_next),
    .wr_lane_o   (wr_lane),
    .wr_pass_o   (wr_pass)
  );

  // Result register; counts saturate to the 5-bit output fields.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_flags_q   <= flags;
      out_removed_q <= (32'(removed) > 32'(COUNT_MAX)) ? CNT_OUT_W'(COUNT_MAX)
                                                       : CNT_OUT_W'(removed);
      out_size_q    <= (32'(size_next) > 32'(COUNT_MAX)) ? CNT_OUT_W'(COUNT_MAX)
                                                         : CNT_OUT_W'(size_next);
    end
  end

  assign res_o.valid              = out_valid_q;
  assign res_o.kept               = out_flags_q.kept;
  assign res_o.dominated_by_front = out_flags_q.dominated;
  assign res_o.overflow_drop      = out_flags_q.overflow;
  assign res_o.removed_count      = out_removed_q;
  assign res_o.front_size         = out_size_q;

  `PFF_ASSERT(a_xfer_starts_sweep, in_xfer |=> (state_q == S_SWEEP), "sweep did not start")
  `PFF_ASSERT(a_commit_shows_result, commit |=> out_valid_q, "committed result not presented")
  `PFF_ASSERT_NEVER(a_flags_exclusive,
    out_valid_q && (out_flags_q.kept + out_flags_q.dominated + out_flags_q.overflow != 2'd1),
    "result flags not exclusive")

endmodule
